/* design/mvm_pkg.sv */
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared types and constants for the matrix-vector multiply unit.
// ----------------------------------------------------------------------------
package mvm_pkg;

  localparam int MAX_COLS = 256;
  localparam int COL_W    = $clog2(MAX_COLS);
  // wide enough for the column register and for MAX_COLS itself
  localparam int CNT_W    = (COL_W + 1 > 9) ? COL_W + 1 : 9;

  localparam int NUM_COLS_W = 9;
  localparam int NUM_ROWS_W = 17;
  localparam int ROW_W      = 16;
  localparam int CFG_DATA_W = 17;

  typedef enum logic {
    REG_NUM_COLS = 1'b0,
    REG_NUM_ROWS = 1'b1
  } cfg_index_t;

  localparam logic ACTION_LOAD   = 1'b0;
  localparam logic ACTION_MATRIX = 1'b1;

  typedef struct packed {
    logic               action;
    logic [7:0]         vec_index;
    logic signed [31:0] value;
  } item_t;

  typedef struct packed {
    logic signed [63:0] row_sum;
    logic [15:0]        row_index;
    logic               last_row;
  } result_t;

endpackage

/* design/matrix_vector_multiply_unit.sv */
// ----------------------------------------------------------------------------
// matrix_vector_multiply_unit
// Streaming dense matrix-vector product with a Q32.32 saturating accumulator.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle. An item with action 0 writes a Q16.16
// vector element into a 256 x 32 single-port store and restarts the product;
// an item with action 1 is the next matrix element in row-major order. Each
// matrix element goes through three registered stages: the vector store read
// at the column counter, a 32 x 32 signed multiply, and the 64-bit saturating
// accumulate, whose add loop sets the rate of one item per cycle. A row
// sum reaches the result register after the row's last element has passed
// through stages a and b. The input is stalled only while a row sum
// leaving the multiply stage finds the result register full and stalled.
// Configuration writes are taken at any time and are always ready; change
// them only while idle.
module matrix_vector_multiply_unit
  import mvm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cfg_index_t            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_MAC,
    KIND_CLOSE
  } kind_t;

  logic [NUM_COLS_W-1:0] num_cols;
  logic [NUM_ROWS_W-1:0] num_rows;

  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;

  logic [31:0] vector_store [MAX_COLS];
  logic [31:0] vec_rd;

  // stage a: accepted item, vector read in flight
  logic              a_valid;
  kind_t             a_kind;
  logic signed [31:0] a_value;
  logic [ROW_W-1:0]  a_row;
  logic              a_last;

  // stage b: product
  logic              b_valid;
  kind_t             b_kind;
  logic signed [63:0] b_prod;
  logic [ROW_W-1:0]  b_row;
  logic              b_last;

  logic signed [63:0] accumulator;

  logic                  advance;
  logic                  accept;
  logic [CNT_W-1:0]      cols_eff;
  logic [NUM_ROWS_W-1:0] rows_eff;
  logic                  row_close;
  logic                  row_last;
  logic                  store_ok;
  logic signed [64:0]    sum_wide;
  logic signed [63:0]    sum_sat;

  assign cfg_ready  = 1'b1;
  assign advance    = !(b_valid && (b_kind == KIND_CLOSE) && result_valid && result_stall);
  assign item_stall = !advance;
  assign accept     = item_valid && advance;

  always_comb begin
    if (num_cols == '0) begin
      cols_eff = CNT_W'(1);
    end else if (CNT_W'(num_cols) > CNT_W'(MAX_COLS)) begin
      cols_eff = CNT_W'(MAX_COLS);
    end else begin
      cols_eff = CNT_W'(num_cols);
    end
    rows_eff  = (num_rows == '0) ? NUM_ROWS_W'(1) : num_rows;
    if (num_rows > NUM_ROWS_W'(65536)) begin
      rows_eff = NUM_ROWS_W'(65536);
    end
    row_close = (CNT_W'(column_count) + CNT_W'(1)) >= cols_eff;
    row_last  = (NUM_ROWS_W'(row_count) + NUM_ROWS_W'(1)) >= rows_eff;
    store_ok  = (32'(item.vec_index) < 32'(MAX_COLS));
  end

  // saturating add of the product into the running sum
  always_comb begin
    sum_wide = 65'(accumulator) + 65'(b_prod);
    if (sum_wide > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
      sum_sat = 64'sh7FFF_FFFF_FFFF_FFFF;
    end else if (sum_wide < -65'sh0_8000_0000_0000_0000) begin
      sum_sat = 64'sh8000_0000_0000_0000;
    end else begin
      sum_sat = sum_wide[63:0];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols <= NUM_COLS_W'(1);
      num_rows <= NUM_ROWS_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NUM_COLS: num_cols <= cfg_data[NUM_COLS_W-1:0];
        REG_NUM_ROWS: num_rows <= cfg_data[NUM_ROWS_W-1:0];
        default:      num_cols <= num_cols;
      endcase
    end
  end

  // vector store, read registered at the column counter
  always_ff @(posedge clk) begin
    if (accept && (item.action == ACTION_LOAD) && store_ok) begin
      vector_store[COL_W'(item.vec_index)] <= item.value;
    end
    if (accept && (item.action == ACTION_MATRIX)) begin
      vec_rd <= vector_store[column_count];
    end
  end

  // counters and stage a
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      a_valid      <= 1'b0;
    end else if (advance) begin
      a_valid <= item_valid;
      if (item_valid) begin
        if (item.action == ACTION_LOAD) begin
          column_count <= '0;
          row_count    <= '0;
        end else if (!row_close) begin
          column_count <= column_count + COL_W'(1);
        end else begin
          column_count <= '0;
          row_count    <= row_last ? '0 : row_count + ROW_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      a_value <= item.value;
      a_row   <= row_count;
      a_last  <= row_last;
      if (item.action == ACTION_LOAD) begin
        a_kind <= KIND_LOAD;
      end else begin
        a_kind <= row_close ? KIND_CLOSE : KIND_MAC;
      end
    end
  end

  // stage b: multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (advance) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && a_valid) begin
      b_kind <= a_kind;
      b_prod <= a_value * $signed(vec_rd);
      b_row  <= a_row;
      b_last <= a_last;
    end
  end

  // stage c: accumulate and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator  <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (advance && b_valid) begin
        unique case (b_kind)
          KIND_LOAD: accumulator <= '0;
          KIND_MAC:  accumulator <= sum_sat;
          KIND_CLOSE: begin
            accumulator  <= '0;
            result_valid <= 1'b1;
          end
          default: accumulator <= accumulator;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && b_valid && (b_kind == KIND_CLOSE)) begin
      result.row_sum   <= sum_sat;
      result.row_index <= b_row;
      result.last_row  <= b_last;
    end
  end

`ifndef ASSERT_OFF
  a_no_result_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  a_result_from_close: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(advance && b_valid && (b_kind == KIND_CLOSE)))
    else $error("result raised without a closing row");

  a_load_clears_sum: assert property (@(posedge clk) disable iff (rst)
    (advance && b_valid && (b_kind == KIND_LOAD)) |=> (accumulator == '0))
    else $error("vector load did not clear the accumulator");

  a_last_row_wraps: assert property (@(posedge clk) disable iff (rst)
    (accept && (item.action == ACTION_MATRIX) && row_close && row_last)
      |=> (row_count == '0) && (column_count == '0))
    else $error("row counter did not wrap after the final row");
`endif

endmodule

/* bench/mvm_row_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvm_row_checker
// Watches the item, result and register channels of the multiply unit. It
// keeps its own vector store, counters and saturating accumulator, queues
// the row sum each accepted matrix element closes, and compares every
// accepted result with the oldest queued row sum.
// ----------------------------------------------------------------------------
module mvm_row_checker
  import mvm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  logic                  item_stall,
  input  item_t                 item,
  input  logic                  result_valid,
  input  logic                  result_stall,
  input  result_t               result,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  cfg_index_t            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending,
  output int                    rows_checked,
  output int                    sat_rows
);

  localparam logic signed [63:0] SUM_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;
  localparam int REPORT_MAX = 10;

  logic [31:0]         vec_mem [MAX_COLS];
  logic [NUM_COLS_W-1:0] cols_reg;
  logic [NUM_ROWS_W-1:0] rows_reg;
  int                  col_cnt;
  int                  row_cnt;
  logic signed [63:0]  acc;
  result_t             row_sum_q [$];

  initial begin
    for (int i = 0; i < MAX_COLS; i++) vec_mem[i] = '0;
    fail_count   = 0;
    pending      = 0;
    rows_checked = 0;
    sat_rows     = 0;
  end

  function automatic int cols_eff();
    if (cols_reg == 0) return 1;
    if (cols_reg > MAX_COLS) return MAX_COLS;
    return int'(cols_reg);
  endfunction

  function automatic int rows_eff();
    if (rows_reg == 0) return 1;
    if (rows_reg > 17'h1_0000) return 65536;
    return int'(rows_reg);
  endfunction

  task automatic report(input result_t want, input result_t got, input bit none_waiting);
    fail_count++;
    if (fail_count <= REPORT_MAX) begin
      if (none_waiting)
        $display("[%0t] unexpected row result: sum=%h idx=%0d last=%b",
                 $realtime, got.row_sum, got.row_index, got.last_row);
      else
        $display("[%0t] row result differs: exp sum=%h idx=%0d last=%b, got sum=%h idx=%0d last=%b",
                 $realtime, want.row_sum, want.row_index, want.last_row,
                 got.row_sum, got.row_index, got.last_row);
    end
  endtask

  always @(posedge clk) begin
    result_t            got;
    result_t            want;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] prod;
    logic signed [63:0] sum;
    if (rst) begin
      cols_reg = NUM_COLS_W'(1);
      rows_reg = NUM_ROWS_W'(1);
      col_cnt  = 0;
      row_cnt  = 0;
      acc      = '0;
      row_sum_q.delete();
    end else begin
      if (result_valid && !result_stall) begin
        got = result;
        if (row_sum_q.size() == 0) begin
          report('0, got, 1'b1);
        end else begin
          want = row_sum_q.pop_front();
          rows_checked++;
          if (got.row_sum !== want.row_sum || got.row_index !== want.row_index ||
              got.last_row !== want.last_row)
            report(want, got, 1'b0);
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NUM_COLS: cols_reg = cfg_data[NUM_COLS_W-1:0];
          REG_NUM_ROWS: rows_reg = cfg_data[NUM_ROWS_W-1:0];
          default: ;
        endcase
      end

      if (item_valid && !item_stall) begin
        if (item.action == ACTION_LOAD) begin
          // a load restarts the product
          vec_mem[item.vec_index] = item.value;
          col_cnt = 0;
          row_cnt = 0;
          acc     = '0;
        end else begin
          a    = {{32{item.value[31]}}, item.value};
          b    = {{32{vec_mem[col_cnt][31]}}, vec_mem[col_cnt]};
          prod = a * b;
          sum  = acc + prod;
          // clamp when both addends share a sign the sum lost
          if (!acc[63] && !prod[63] && sum[63]) sum = SUM_MAX;
          else if (acc[63] && prod[63] && !sum[63]) sum = SUM_MIN;
          acc = sum;
          if (col_cnt + 1 < cols_eff()) begin
            col_cnt++;
          end else begin
            want.row_sum   = acc;
            want.row_index = row_cnt[15:0];
            want.last_row  = (row_cnt + 1 >= rows_eff());
            row_sum_q.push_back(want);
            if (acc == SUM_MAX || acc == SUM_MIN) sat_rows++;
            acc     = '0;
            col_cnt = 0;
            row_cnt = want.last_row ? 0 : ((row_cnt + 1) & 32'hffff);
          end
        end
      end
    end
    pending = row_sum_q.size();
  end

endmodule

/* bench/matrix_vector_multiply_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_vector_multiply_unit_tb
// Drives vector loads, matrix rows and register writes into the multiply
// unit with bursty input and a stalling result side, and lets the row
// checker judge every row sum. Covers clamped shapes, saturation, loads and
// register writes in the middle of a row, and a long result hold-off.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_unit_tb;
  import mvm_pkg::*;

  localparam int LIMIT      = 400000;
  localparam int DRAIN      = 12;
  localparam int LONG_HOLD  = 120;
  localparam int RAND_ITEMS = 380;

  logic                  clk;
  logic                  rst;
  logic                  item_valid;
  logic                  item_stall;
  item_t                 item;
  logic                  result_valid;
  logic                  result_stall;
  result_t               result;
  logic                  cfg_valid;
  logic                  cfg_ready;
  cfg_index_t            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int rows_checked;
  int sat_rows;

  bit written [MAX_COLS];
  int cols_len   = 1;
  int n_sent     = 0;
  int cfg_writes = 0;
  int burst_left = 0;
  int cycle_cnt  = 0;
  bit steady     = 1'b0;
  bit hold_req   = 1'b0;

  matrix_vector_multiply_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  mvm_row_checker row_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .rows_checked (rows_checked),
    .sat_rows     (sat_rows)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: free, light and heavy stall stretches, plus a long hold on request
  initial begin
    int mode;
    int mode_left;
    int hold_cnt;
    mode      = 0;
    mode_left = 0;
    hold_cnt  = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = LONG_HOLD;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        result_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(8, 64);
        end
        mode_left--;
        case (mode)
          0:       result_stall <= 1'b0;
          1:       result_stall <= ($urandom_range(0, 3) == 0);
          default: result_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  function automatic int vec_len(input logic [NUM_COLS_W-1:0] c);
    if (c == 0) return 1;
    if (c > MAX_COLS) return MAX_COLS;
    return int'(c);
  endfunction

  function automatic logic [31:0] rand_value();
    int s;
    s = int'($urandom_range(0, 393216)) - 196608;
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      4, 5, 6: return s;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_item(input logic act, input logic [7:0] idx, input logic [31:0] v);
    int gap;
    if (burst_left == 0) begin
      gap        = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_valid      <= 1'b1;
    item.action     <= act;
    item.vec_index  <= idx;
    item.value      <= v;
    if (act == ACTION_LOAD) written[idx] = 1'b1;
    do @(posedge clk); while (item_stall);
    n_sent++;
  endtask

  task automatic send_matrix(input int n);
    for (int i = 0; i < n; i++) send_item(ACTION_MATRIX, 8'($urandom()), rand_value());
  endtask

  // every entry of 0..len-1, in shuffled order
  task automatic load_vector(input int len);
    int order [MAX_COLS];
    int j;
    int t;
    for (int i = 0; i < len; i++) order[i] = i;
    for (int i = len - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < len; i++) send_item(ACTION_LOAD, 8'(order[i]), rand_value());
  endtask

  task automatic quiesce();
    item_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_NUM_COLS) cols_len = vec_len(data[NUM_COLS_W-1:0]);
    cfg_writes++;
  endtask

  task automatic set_shape(input logic [CFG_DATA_W-1:0] c, input logic [CFG_DATA_W-1:0] r);
    quiesce();
    if ($urandom_range(0, 1)) begin
      write_reg(REG_NUM_COLS, c);
      write_reg(REG_NUM_ROWS, r);
    end else begin
      write_reg(REG_NUM_ROWS, r);
      write_reg(REG_NUM_COLS, c);
    end
  endtask

  task automatic random_phase();
    logic [NUM_COLS_W-1:0] c;
    logic [CFG_DATA_W-1:0] r;
    int                    nrows;
    bit                    need_load;
    case ($urandom_range(0, 9))
      0:       c = '0;
      1:       c = NUM_COLS_W'($urandom_range(9, 32));
      default: c = NUM_COLS_W'($urandom_range(1, 8));
    endcase
    case ($urandom_range(0, 5))
      0:       r = CFG_DATA_W'($urandom());
      1:       r = '0;
      default: r = CFG_DATA_W'($urandom_range(1, 6));
    endcase
    set_shape({8'($urandom()), c}, r);
    steady = ($urandom_range(0, 3) == 0);
    need_load = 1'b0;
    for (int i = 0; i < cols_len; i++) if (!written[i]) need_load = 1'b1;
    if (need_load || $urandom_range(0, 1)) load_vector(cols_len);
    nrows = $urandom_range(1, 5);
    for (int i = 0; i < nrows * cols_len; i++) begin
      // a stray load now and then restarts the product mid-row
      if ($urandom_range(0, 29) == 0) send_item(ACTION_LOAD, 8'($urandom()), rand_value());
      send_item(ACTION_MATRIX, 8'($urandom()), rand_value());
    end
    // sometimes leave a row open across the next register writes
    if ($urandom_range(0, 4) == 0) send_matrix($urandom_range(1, cols_len));
  endtask

  initial begin
    int rand_start;
    int rows_start;
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_NUM_COLS;
    cfg_data   <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset shape, one element per row
    send_item(ACTION_LOAD, 8'h00, 32'h7fff_ffff);
    send_item(ACTION_MATRIX, 8'h00, 32'h7fff_ffff);

    // zero counts clamp to one
    set_shape('0, '0);
    send_item(ACTION_MATRIX, 8'hff, 32'h8000_0000);

    // saturation at both limits
    set_shape(CFG_DATA_W'(4), CFG_DATA_W'(3));
    for (int i = 0; i < 4; i++) send_item(ACTION_LOAD, 8'(i), 32'h8000_0000);
    for (int i = 0; i < 4; i++) send_item(ACTION_MATRIX, 8'h00, 32'h8000_0000);
    for (int i = 0; i < 4; i++) send_item(ACTION_MATRIX, 8'h00, 32'h7fff_ffff);

    // load in the middle of a row restarts the product
    send_matrix(2);
    send_item(ACTION_LOAD, 8'hff, 32'hffff_ffff);
    send_matrix(4);

    // shrinking the column count mid-row closes the row on the next element
    send_matrix(2);
    quiesce();
    write_reg(REG_NUM_COLS, CFG_DATA_W'(2));
    send_matrix(1);

    // oversized row count clamps to the full row range
    set_shape(CFG_DATA_W'(2), 17'h1_ffff);
    send_matrix(4);

    // long result hold-off while items keep coming
    set_shape(CFG_DATA_W'(1), CFG_DATA_W'(7));
    steady   = 1'b1;
    hold_req = 1'b1;
    send_matrix(40);

    rand_start = n_sent;
    rows_start = rows_checked;
    while (n_sent - rand_start < RAND_ITEMS || rows_checked - rows_start < 40)
      random_phase();

    quiesce();
    $display("%0d input transactions, %0d register writes, %0d row sums checked (%0d saturated)",
             n_sent, cfg_writes, rows_checked, sat_rows);
    if (fail_count == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
